>>> src/des_ks_pkg.sv
// Shared constants, types and permutation functions for the DES key schedule.
package des_ks_pkg;

    localparam int KEY_W   = 64;
    localparam int HALF_W  = 28;
    localparam int CD_W    = 2 * HALF_W;
    localparam int RK_W    = 48;
    localparam int ROUNDS  = 16;
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam int RNUM_W  = 5;
    localparam int SCHED_W = 16;

    localparam logic [SCHED_W-1:0] SCHED_RESET = 16'h8103;

    typedef logic [HALF_W-1:0] half_t;

    typedef struct packed {
        half_t c;
        half_t d;
    } cd_t;

    localparam logic [6:0] PC1_TABLE [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TABLE [RK_W] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    function automatic cd_t pc1(input logic [KEY_W-1:0] k);
        logic [CD_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CD_W; i++) begin
            acc[CD_W-1-i] = k[6'(KEY_W - int'(PC1_TABLE[i]))];
        end
        return cd_t'(acc);
    endfunction

    function automatic logic [RK_W-1:0] pc2(input cd_t cd);
        logic [RK_W-1:0] acc;
        logic [CD_W-1:0] src;
        src = cd;
        acc = '0;
        for (int i = 0; i < RK_W; i++) begin
            acc[RK_W-1-i] = src[6'(CD_W - int'(PC2_TABLE[i]))];
        end
        return acc;
    endfunction

endpackage

>>> src/des_ks_rot.sv
// Shared round unit: rotates both key halves by one or two and applies PC-2.
module des_ks_rot (
    input  des_ks_pkg::cd_t                   cd_in,
    input  logic                              single,
    output des_ks_pkg::cd_t                   cd_out,
    output logic [des_ks_pkg::RK_W-1:0]       round_key
);

    localparam int HW = des_ks_pkg::HALF_W;

    always_comb begin
        if (single) begin
            cd_out.c = {cd_in.c[HW-2:0], cd_in.c[HW-1]};
            cd_out.d = {cd_in.d[HW-2:0], cd_in.d[HW-1]};
        end else begin
            cd_out.c = {cd_in.c[HW-3:0], cd_in.c[HW-1:HW-2]};
            cd_out.d = {cd_in.d[HW-3:0], cd_in.d[HW-1:HW-2]};
        end
    end

    assign round_key = des_ks_pkg::pc2(cd_out);

endmodule

>>> src/des_key_schedule.sv
// DES key schedule top level: sequencer, rotation register and result register.
//
// One key is taken when s_ready is high; the block then issues its sixteen
// round keys, one per cycle unless m_ready stalls the result register, through
// a single shared rotate and PC-2 unit, rounds 1 to 16 in order with m_last_key
// on round 16. After acceptance PC-1 loads the rotation register, then the rounds
// are issued; a round waits while the result register holds an untaken key.
// s_ready is low while rounds are being issued. The round key register lets a
// new key load while round 16 still waits on m_ready.
// cfg_we writes cfg_wdata into the rotation schedule (bit r-1 set: round r
// rotates by one, else by two); reset value 0x8103 is the standard schedule.
module des_key_schedule (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [des_ks_pkg::KEY_W-1:0]        s_key,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [des_ks_pkg::RK_W-1:0]         m_round_key,
    output logic [des_ks_pkg::RNUM_W-1:0]       m_round_number,
    output logic                                m_last_key,
    input  logic                                cfg_we,
    input  logic [des_ks_pkg::SCHED_W-1:0]      cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [des_ks_pkg::ROUND_W-1:0] LAST_ROUND =
        des_ks_pkg::ROUND_W'(des_ks_pkg::ROUNDS - 1);

    logic                                 state_reg, state_next;
    logic [des_ks_pkg::ROUND_W-1:0]       round_reg, round_next;
    des_ks_pkg::cd_t                      cd_reg, cd_next;
    logic [des_ks_pkg::SCHED_W-1:0]       sched_reg;
    logic                                 m_valid_reg, m_valid_next;
    logic [des_ks_pkg::RK_W-1:0]          rk_reg;
    logic [des_ks_pkg::RNUM_W-1:0]        rnum_reg;
    logic                                 last_reg;

    des_ks_pkg::cd_t                      cd_rot;
    logic [des_ks_pkg::RK_W-1:0]          rk_rot;
    logic                                 accept;
    logic                                 fire;

    des_ks_rot u_rot (
        .cd_in     (cd_reg),
        .single    (sched_reg[round_reg]),
        .cd_out    (cd_rot),
        .round_key (rk_rot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign fire    = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        cd_next      = cd_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cd_next    = des_ks_pkg::pc1(s_key);
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (fire) begin
                    cd_next      = cd_rot;
                    round_next   = round_reg + 1'b1;
                    m_valid_next = 1'b1;
                    if (round_reg == LAST_ROUND) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
            sched_reg   <= des_ks_pkg::SCHED_RESET;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                sched_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cd_reg <= cd_next;
        if (fire) begin
            rk_reg   <= rk_rot;
            rnum_reg <= des_ks_pkg::RNUM_W'(round_reg) + 1'b1;
            last_reg <= (round_reg == LAST_ROUND);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_round_key    = rk_reg;
    assign m_round_number = rnum_reg;
    assign m_last_key     = last_reg;

endmodule

>>> src/des_ks_checker.sv
// Port-level checker for the DES key schedule, bound to the top level.
module des_ks_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [des_ks_pkg::RK_W-1:0]         m_round_key,
    input logic [des_ks_pkg::RNUM_W-1:0]       m_round_number,
    input logic                                m_last_key
);

    localparam logic [des_ks_pkg::RNUM_W-1:0] RNUM_LAST =
        des_ks_pkg::RNUM_W'(des_ks_pkg::ROUNDS);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high right after an item was accepted");

    a_round_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_round_number != '0) && (m_round_number <= RNUM_LAST))
        else $error("round number out of range");

    a_last_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_key == (m_round_number == RNUM_LAST)))
        else $error("last flag does not match round sixteen");

    a_round_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_key) ##1 m_valid
            |-> m_round_number == $past(m_round_number) + 1'b1)
        else $error("round keys out of order");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_round_key)
            && $stable(m_round_number))
        else $error("stalled item changed");

endmodule

bind des_key_schedule des_ks_checker u_des_ks_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_round_key    (m_round_key),
    .m_round_number (m_round_number),
    .m_last_key     (m_last_key)
);

>>> verif/des_key_schedule_tb.sv
// Self-checking testbench for des_key_schedule: random keys, schedules and handshake stalls.
module des_key_schedule_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 44;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned HOLDOFF_AT = 1000;

    localparam int unsigned PC1_MAP [56] = '{
        57, 49, 41, 33, 25, 17,  9,
         1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27,
        19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,
         7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29,
        21, 13,  5, 28, 20, 12,  4
    };

    localparam int unsigned PC2_MAP [48] = '{
        14, 17, 11, 24,  1,  5,
         3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8,
        16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55,
        30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53,
        46, 42, 50, 36, 29, 32
    };

    localparam logic [des_ks_pkg::KEY_W-1:0] EDGE_KEYS [14] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h1334_5779_9BBC_DFF1,
        64'h0101_0101_0101_0101,
        64'hFEFE_FEFE_FEFE_FEFE,
        64'h1F1F_1F1F_0E0E_0E0E,
        64'hE0E0_E0E0_F1F1_F1F1,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555,
        64'h8000_0000_0000_0000,
        64'h0000_0000_0000_0001,
        64'h0000_0000_0000_0002,
        64'hFFFF_FFFF_0000_0000,
        64'h0000_0000_FFFF_FFFF
    };

    class round_key_scoreboard;
        typedef struct {
            logic [des_ks_pkg::RK_W-1:0]   round_key;
            logic [des_ks_pkg::RNUM_W-1:0] round_number;
            logic                          last_key;
        } round_key_t;

        round_key_t                     expected_round_keys [$];
        logic [des_ks_pkg::SCHED_W-1:0] schedule;
        int unsigned                    errors;

        function new();
            schedule = des_ks_pkg::SCHED_RESET;
            errors = 0;
        endfunction

        function void set_schedule(input logic [des_ks_pkg::SCHED_W-1:0] value);
            schedule = value;
        endfunction

        function void note_key(input logic [des_ks_pkg::KEY_W-1:0] key);
            logic [des_ks_pkg::CD_W-1:0] cd;
            logic [des_ks_pkg::HALF_W-1:0] c;
            logic [des_ks_pkg::HALF_W-1:0] d;
            logic [des_ks_pkg::RK_W-1:0] rk;
            round_key_t entry;
            for (int i = 0; i < 56; i++) begin
                cd[55-i] = key[64-PC1_MAP[i]];
            end
            c = cd[55:28];
            d = cd[27:0];
            for (int r = 0; r < 16; r++) begin
                if (schedule[r]) begin
                    c = {c[26:0], c[27]};
                    d = {d[26:0], d[27]};
                end else begin
                    c = {c[25:0], c[27:26]};
                    d = {d[25:0], d[27:26]};
                end
                cd = {c, d};
                for (int i = 0; i < 48; i++) begin
                    rk[47-i] = cd[56-PC2_MAP[i]];
                end
                entry.round_key = rk;
                entry.round_number = des_ks_pkg::RNUM_W'(r + 1);
                entry.last_key = (r == 15);
                expected_round_keys.push_back(entry);
            end
        endfunction

        function void check_round_key(input logic [des_ks_pkg::RK_W-1:0] round_key,
                                      input logic [des_ks_pkg::RNUM_W-1:0] round_number,
                                      input logic last_key);
            round_key_t exp_rk;
            if (expected_round_keys.size() == 0) begin
                $error("unexpected item: round_key %h round_number %0d", round_key,
                       round_number);
                errors++;
                return;
            end
            exp_rk = expected_round_keys.pop_front();
            if (round_key !== exp_rk.round_key) begin
                $error("round_key: expected %h, actual %h", exp_rk.round_key, round_key);
                errors++;
            end
            if (round_number !== exp_rk.round_number) begin
                $error("round_number: expected %0d, actual %0d", exp_rk.round_number,
                       round_number);
                errors++;
            end
            if (last_key !== exp_rk.last_key) begin
                $error("last_key: expected %b, actual %b", exp_rk.last_key, last_key);
                errors++;
            end
        endfunction

        function int pending();
            return expected_round_keys.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [des_ks_pkg::KEY_W-1:0] s_key = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [des_ks_pkg::RK_W-1:0] m_round_key;
    logic [des_ks_pkg::RNUM_W-1:0] m_round_number;
    logic m_last_key;
    logic cfg_we = 1'b0;
    logic [des_ks_pkg::SCHED_W-1:0] cfg_wdata = '0;

    round_key_scoreboard sb;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned cycle_count = 0;

    des_key_schedule u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key          (s_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_round_key    (m_round_key),
        .m_round_number (m_round_number),
        .m_last_key     (m_last_key),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [des_ks_pkg::KEY_W-1:0] random_key();
        logic [des_ks_pkg::KEY_W-1:0] raw;
        logic [des_ks_pkg::KEY_W-1:0] sparse;
        raw = {$urandom, $urandom};
        sparse = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        unique case ($urandom_range(0, 9))
            0: return sparse;
            1: return ~sparse;
            default: return raw;
        endcase
    endfunction

    task automatic send_key(input logic [des_ks_pkg::KEY_W-1:0] key);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_key <= key;
        do @(posedge aclk); while (!s_ready);
        sb.note_key(key);
    endtask

    task automatic write_schedule(input logic [des_ks_pkg::SCHED_W-1:0] value);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_schedule(value);
    endtask

    initial begin
        int unsigned taken;
        int unsigned holdoff_left;
        bit holdoff_done;
        taken = 0;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_round_key(m_round_key, m_round_number, m_last_key);
                taken++;
            end
            if (!holdoff_done && taken >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** des_key_schedule: FAILED **");
        $finish;
    end

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int p = 0; p < 7; p++) begin
            src_idle_pct = (p < 3) ? 18 : (p < 5) ? 53 : 0;
            sink_idle_pct = (p < 3) ? 53 : (p < 5) ? 18 : 0;
            unique case (p)
                1: write_schedule(16'h0000);
                2: write_schedule(16'hFFFF);
                4: write_schedule(des_ks_pkg::SCHED_RESET);
                3, 5, 6: write_schedule(des_ks_pkg::SCHED_W'($urandom));
                default: ;
            endcase
            if (p == 0) begin
                foreach (EDGE_KEYS[i]) send_key(EDGE_KEYS[i]);
            end
            repeat (ITEMS_PER_PHASE) send_key(random_key());
            s_valid <= 1'b0;
        end
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** des_key_schedule: PASSED **");
        end else begin
            $display("** des_key_schedule: FAILED **");
        end
        $finish;
    end

endmodule
